// ----- design/wppt_pkg.sv -----
// Shared types, widths and the microcode table for the weighted portfolio price tracker.
// Depends on nothing; imported by weighted_portfolio_price_tracker_unit, the checker and the testbench.
package wppt_pkg;

  // Field widths
  localparam int PRICE_W   = 32;
  localparam int WEIGHT_W  = 24;
  localparam int TOTAL_W   = 64;
  localparam int DIFF_W    = PRICE_W + 1;
  localparam int PROD_W    = DIFF_W + WEIGHT_W;
  localparam int SEC_IDX_W = 3;
  localparam int CFG_IDX_W = 3;

  localparam int NUM_SECURITIES_DEF = 8;

  // Total after reset: 1000 price units with 24 fraction bits
  localparam logic signed [TOTAL_W-1:0] TOTAL_RESET = 64'sd16777216000;
  localparam logic signed [TOTAL_W-1:0] TOTAL_MAX   = {1'b0, {(TOTAL_W-1){1'b1}}};
  localparam logic signed [TOTAL_W-1:0] TOTAL_MIN   = {1'b1, {(TOTAL_W-1){1'b0}}};

  // Microcode addresses
  typedef enum logic [2:0] {
    STEP_ACCEPT = 3'd0,  // take request, multiply price change by weight
    STEP_UPDATE = 3'd1,  // accumulate, give result or mark seen
    STEP_CHECK  = 3'd2,  // all weighted securities seen?
    STEP_INIT   = 3'd3,  // clear total for rebuild
    STEP_RMUL   = 3'd4,  // rebuild: weight times last price
    STEP_RACC   = 3'd5   // rebuild: accumulate, loop
  } step_t;

  // Branch conditions
  typedef enum logic [2:0] {
    COND_NEVER,
    COND_NO_REQ,
    COND_ALL_READY,
    COND_INCOMPLETE,
    COND_MORE
  } cond_t;

  // One control word: branch to jump when the condition holds, else to next
  typedef struct packed {
    step_t next;
    step_t jump;
    cond_t cond;
    logic  mul_delta;
    logic  mul_rebuild;
    logic  acc_add;
    logic  acc_clear;
    logic  emit;
    logic  mark_seen;
    logic  set_ready;
    logic  cnt_clear;
    logic  cnt_inc;
  } ucode_t;

  // Control store
  function automatic ucode_t ucode_rom(step_t s);
    ucode_t w;
    w = '{next: STEP_ACCEPT, jump: STEP_ACCEPT, cond: COND_NEVER, default: 1'b0};
    unique case (s)
      STEP_ACCEPT: begin
        w.next = STEP_UPDATE; w.jump = STEP_ACCEPT; w.cond = COND_NO_REQ;
        w.mul_delta = 1'b1;
      end
      STEP_UPDATE: begin
        w.next = STEP_CHECK; w.jump = STEP_ACCEPT; w.cond = COND_ALL_READY;
        w.acc_add = 1'b1; w.emit = 1'b1; w.mark_seen = 1'b1;
      end
      STEP_CHECK: begin
        w.next = STEP_INIT; w.jump = STEP_ACCEPT; w.cond = COND_INCOMPLETE;
      end
      STEP_INIT: begin
        w.next = STEP_RMUL; w.cond = COND_NEVER;
        w.acc_clear = 1'b1; w.set_ready = 1'b1; w.cnt_clear = 1'b1;
      end
      STEP_RMUL: begin
        w.next = STEP_RACC; w.cond = COND_NEVER;
        w.mul_rebuild = 1'b1;
      end
      STEP_RACC: begin
        w.next = STEP_ACCEPT; w.jump = STEP_RMUL; w.cond = COND_MORE;
        w.acc_add = 1'b1; w.cnt_inc = 1'b1;
      end
      default: begin
        w.next = STEP_ACCEPT; w.cond = COND_NEVER;
      end
    endcase
    return w;
  endfunction

endpackage

// ----- design/weighted_portfolio_price_tracker_unit.sv -----
// Steps: a request that gives a result passes accept, then update; the product is registered
// in accept and the result in update, which holds while an earlier result still waits.
// Requests before the portfolio is ready pass accept, update and check, and an index beyond
// the portfolio accept only; the ready step runs init, then rmul and racc once per security
// on one shared multiplier. A new request is taken only back in accept, not while one is in flight.
// Reset: synchronous; clears prices, weights, seen mask and sets the total to 1000.
// Top level of the weighted portfolio price tracker; microcoded sequencer plus datapath.
// Depends on wppt_pkg.
module weighted_portfolio_price_tracker_unit
  import wppt_pkg::*;
#(
  parameter int NUM_SECURITIES = NUM_SECURITIES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // request channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [SEC_IDX_W-1:0]        security_index,
  input  logic signed [PRICE_W-1:0]   new_price,
  // result channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [TOTAL_W-1:0]   weighted_total,
  // configuration
  input  logic                        cfg_write_en,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [WEIGHT_W-1:0]         cfg_data
);

  localparam int IDX_W = $clog2(NUM_SECURITIES);
  localparam logic [SEC_IDX_W:0] NUM_L    = (SEC_IDX_W+1)'(NUM_SECURITIES);
  localparam logic [IDX_W-1:0]   CNT_LAST = IDX_W'(NUM_SECURITIES - 1);

  // State
  step_t                      pc;
  logic [IDX_W-1:0]           cnt;
  logic [IDX_W-1:0]           idx_reg;
  logic [NUM_SECURITIES-1:0]  seen_mask;
  logic                       all_ready;
  logic signed [PRICE_W-1:0]  last_price [NUM_SECURITIES];
  logic signed [WEIGHT_W-1:0] weight     [NUM_SECURITIES];
  logic signed [TOTAL_W-1:0]  total;
  logic signed [PROD_W-1:0]   prod;

  // Control and datapath nets
  ucode_t                     uc;
  step_t                      pc_next;
  logic                       in_range;
  logic                       cfg_in_range;
  logic                       req_ok;
  logic                       stall;
  logic                       cond_true;
  logic                       incomplete;
  logic                       emit_fire;
  logic [IDX_W-1:0]           rd_addr;
  logic signed [PRICE_W-1:0]  rd_price;
  logic signed [WEIGHT_W-1:0] rd_weight;
  logic signed [DIFF_W-1:0]   mul_a;
  logic signed [PROD_W-1:0]   mul_p;
  logic signed [TOTAL_W:0]    sum_wide;
  logic signed [TOTAL_W-1:0]  sat_val;

  assign uc = ucode_rom(pc);

  assign in_range     = {1'b0, security_index} < NUM_L;
  assign cfg_in_range = {1'b0, cfg_index} < NUM_L;
  assign in_ready     = (pc == STEP_ACCEPT);
  assign req_ok       = in_valid && in_range;

  // Hold the update step while an earlier result still waits
  assign stall     = uc.emit && all_ready && out_valid && !out_ready;
  assign emit_fire = uc.emit && all_ready && !stall;

  // Single read port on prices and weights
  assign rd_addr   = (pc == STEP_ACCEPT) ? security_index[IDX_W-1:0] : cnt;
  assign rd_price  = last_price[rd_addr];
  assign rd_weight = weight[rd_addr];

  // Shared multiplier: price change on update, last price on rebuild
  assign mul_a = uc.mul_delta ? ({new_price[PRICE_W-1], new_price} -
                                 {rd_price[PRICE_W-1], rd_price})
                              : {rd_price[PRICE_W-1], rd_price};
  assign mul_p = mul_a * rd_weight;

  // Saturating accumulate
  assign sum_wide = {total[TOTAL_W-1], total} +
                    {{(TOTAL_W+1-PROD_W){prod[PROD_W-1]}}, prod};
  assign sat_val  = (sum_wide[TOTAL_W] != sum_wide[TOTAL_W-1])
                    ? (sum_wide[TOTAL_W] ? TOTAL_MIN : TOTAL_MAX)
                    : sum_wide[TOTAL_W-1:0];

  // Any weighted security not yet seen
  always_comb begin
    incomplete = 1'b0;
    for (int i = 0; i < NUM_SECURITIES; i++) begin
      if (weight[i] != '0 && !seen_mask[i]) incomplete = 1'b1;
    end
  end

  // Branch condition select
  always_comb begin
    unique case (uc.cond)
      COND_NEVER:      cond_true = 1'b0;
      COND_NO_REQ:     cond_true = !req_ok;
      COND_ALL_READY:  cond_true = all_ready;
      COND_INCOMPLETE: cond_true = incomplete;
      COND_MORE:       cond_true = (cnt != CNT_LAST);
      default:         cond_true = 1'b0;
    endcase
  end

  assign pc_next = stall ? pc : (cond_true ? uc.jump : uc.next);

  // Sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= STEP_ACCEPT;
      cnt       <= '0;
      seen_mask <= '0;
      all_ready <= 1'b0;
      total     <= TOTAL_RESET;
      out_valid <= 1'b0;
      for (int i = 0; i < NUM_SECURITIES; i++) begin
        last_price[i] <= '0;
        weight[i]     <= '0;
      end
    end else begin
      pc <= pc_next;

      // weight writes; slots beyond the portfolio are never used
      if (cfg_write_en && cfg_in_range) weight[cfg_index[IDX_W-1:0]] <= cfg_data;

      // accept: keep the new price and its index
      if (uc.mul_delta && req_ok) begin
        last_price[security_index[IDX_W-1:0]] <= new_price;
        idx_reg <= security_index[IDX_W-1:0];
      end

      if (uc.mul_delta || uc.mul_rebuild) prod <= mul_p;

      // total
      if (uc.acc_clear)              total <= '0;
      else if (uc.acc_add && !stall) total <= sat_val;

      if (uc.mark_seen && !all_ready) seen_mask[idx_reg] <= 1'b1;
      if (uc.set_ready) all_ready <= 1'b1;

      if (uc.cnt_clear)    cnt <= '0;
      else if (uc.cnt_inc) cnt <= cnt + 1'b1;

      // output register
      if (emit_fire) begin
        out_valid      <= 1'b1;
        weighted_total <= sat_val;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Checks
  a_result_needs_ready: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> all_ready)
    else $error("result given before portfolio ready");

  a_seen_frozen: assert property (@(posedge clk) disable iff (rst)
    (all_ready && $past(all_ready)) |-> $stable(seen_mask))
    else $error("seen mask changed after ready step");

  a_rebuild_once: assert property (@(posedge clk) disable iff (rst)
    (pc == STEP_INIT) |-> !$past(all_ready))
    else $error("rebuild started twice");

  a_accept_goes_update: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_range) |=> (pc == STEP_UPDATE))
    else $error("accepted request not followed by update step");

endmodule

// ----- tb/portfolio_total_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard for the weighted portfolio price tracker: watches the request, result and
// weight ports, predicts every portfolio total and compares it with what the block gives.
// Depends on wppt_pkg.
module portfolio_total_checker
  import wppt_pkg::*;
#(
  parameter int NUM_SECURITIES = NUM_SECURITIES_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic [SEC_IDX_W-1:0]      security_index,
  input  logic signed [PRICE_W-1:0] new_price,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic signed [TOTAL_W-1:0] weighted_total,
  input  logic                      cfg_write_en,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [WEIGHT_W-1:0]       cfg_data,
  output int                        mismatches,
  output int                        totals_outstanding
);

  localparam int SLOTS = 1 << SEC_IDX_W;

  // Own copy of the block's weights and tracking state
  logic signed [WEIGHT_W-1:0] weight_of [SLOTS];
  logic signed [PRICE_W-1:0]  held_price [SLOTS];
  logic [SLOTS-1:0]           seen;
  logic                       tracking;
  logic signed [TOTAL_W-1:0]  total;
  logic signed [TOTAL_W-1:0]  totals_due [$];

  task automatic report_mismatch(input string what, input logic signed [TOTAL_W-1:0] want,
                                 input logic signed [TOTAL_W-1:0] got);
    $display("%0t: %s: expected %0d, got %0d", $time, what, want, got);
    mismatches++;
  endtask

  // Signed 64-bit addition clamped at the limits
  function automatic logic signed [TOTAL_W-1:0] clamp_sum(input logic signed [TOTAL_W-1:0] a,
                                                          input logic signed [TOTAL_W-1:0] b);
    logic [TOTAL_W:0] s;
    s = {a[TOTAL_W-1], a} + {b[TOTAL_W-1], b};
    if (s[TOTAL_W] != s[TOTAL_W-1])
      return s[TOTAL_W] ? TOTAL_MIN : TOTAL_MAX;
    return s[TOTAL_W-1:0];
  endfunction

  // A security with zero weight never holds the portfolio back
  function automatic bit all_weighted_seen();
    for (int i = 0; i < NUM_SECURITIES; i++)
      if (weight_of[i] != 0 && !seen[i])
        return 1'b0;
    return 1'b1;
  endfunction

  // One price update: move the total by the weighted change, rebuild it on the ready step
  task automatic predict_update(input int sec, input logic signed [PRICE_W-1:0] price);
    longint change;
    if (sec >= NUM_SECURITIES)
      return;
    change = (longint'(price) - longint'(held_price[sec])) * longint'(weight_of[sec]);
    held_price[sec] = price;
    total = clamp_sum(total, change);
    if (tracking) begin
      totals_due.push_back(total);
      return;
    end
    seen[sec] = 1'b1;
    if (all_weighted_seen()) begin
      tracking = 1'b1;
      total = '0;
      for (int i = 0; i < NUM_SECURITIES; i++)
        total = clamp_sum(total, longint'(held_price[i]) * longint'(weight_of[i]));
    end
  endtask

  task automatic check_total(input logic signed [TOTAL_W-1:0] got);
    if (totals_due.size() == 0) begin
      report_mismatch("weighted_total with no request behind it", '0, got);
      return;
    end
    if (got !== totals_due[0])
      report_mismatch("weighted_total", totals_due[0], got);
    void'(totals_due.pop_front());
  endtask

  // Sample all three ports at the edge; an older result is matched before a new request
  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        weight_of[i]  = '0;
        held_price[i] = '0;
      end
      seen       = '0;
      tracking   = 1'b0;
      total      = TOTAL_RESET;
      mismatches = 0;
      totals_due.delete();
    end else begin
      if (out_valid && out_ready)
        check_total(weighted_total);
      if (cfg_write_en)
        weight_of[cfg_index] = cfg_data;
      if (in_valid && in_ready)
        predict_update(int'(security_index), new_price);
    end
    totals_outstanding <= totals_due.size();
  end

endmodule

// ----- tb/weighted_portfolio_price_tracker_unit_tb.sv -----
`timescale 1ns / 100ps
// Top of the testbench for the weighted portfolio price tracker: clock, reset, request and
// weight stimulus, result back-pressure and the verdict. Depends on wppt_pkg and the checker.
module weighted_portfolio_price_tracker_unit_tb;
  import wppt_pkg::*;

  localparam int SETTLE_CYCLES  = 40;    // room for the ready step, which gives no result
  localparam int IDLE_LIMIT     = 2000;
  localparam int RISING_FLIPS   = 40;
  localparam int FALLING_FLIPS  = 74;
  localparam int TOTAL_REQUESTS = 1100;

  localparam logic signed [WEIGHT_W-1:0] W_MAX = {1'b0, {(WEIGHT_W-1){1'b1}}};
  localparam logic signed [WEIGHT_W-1:0] W_MIN = {1'b1, {(WEIGHT_W-1){1'b0}}};
  localparam logic signed [WEIGHT_W-1:0] W_ONE = 24'sh010000;
  localparam logic signed [PRICE_W-1:0]  P_MAX = {1'b0, {(PRICE_W-1){1'b1}}};
  localparam logic signed [PRICE_W-1:0]  P_MIN = {1'b1, {(PRICE_W-1){1'b0}}};

  logic                      clk;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [SEC_IDX_W-1:0]      security_index = '0;
  logic signed [PRICE_W-1:0] new_price = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [TOTAL_W-1:0] weighted_total;
  logic                      cfg_write_en = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [WEIGHT_W-1:0]       cfg_data = '0;

  int mismatches;
  int totals_outstanding;
  int gap_pct = 0;
  int stall_pct = 0;
  int stall_left = 0;
  int idle_cycles = 0;
  int requests_sent = 0;
  logic signed [WEIGHT_W-1:0] weights [8];

  weighted_portfolio_price_tracker_unit uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .security_index(security_index), .new_price(new_price),
    .out_valid(out_valid), .out_ready(out_ready), .weighted_total(weighted_total),
    .cfg_write_en(cfg_write_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  portfolio_total_checker watch (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .security_index(security_index), .new_price(new_price),
    .out_valid(out_valid), .out_ready(out_ready), .weighted_total(weighted_total),
    .cfg_write_en(cfg_write_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .totals_outstanding(totals_outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Result side: random stalls, mostly short, now and then long
  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 99) < stall_pct)
        stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 3);
    end
  end

  // Watchdog: too long with nothing moving on any port
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_write_en) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL weighted_portfolio_price_tracker_unit");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 99) >= gap_pct)
      return 0;
    if ($urandom_range(0, 9) == 0)
      return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // Idle rate for one phase; a quarter of phases run flat out
  function automatic int phase_idle_pct();
    if ($urandom_range(0, 3) == 0)
      return 0;
    return $urandom_range(5, 40);
  endfunction

  function automatic logic signed [WEIGHT_W-1:0] random_weight();
    case ($urandom_range(0, 9))
      0, 1:    return '0;
      2:       return W_MAX;
      3:       return W_MIN;
      4:       return $urandom_range(0, 1) ? 24'sd1 : -24'sd1;
      5:       return $urandom_range(0, 1) ? W_ONE : -W_ONE;
      default: return WEIGHT_W'($urandom());
    endcase
  endfunction

  function automatic logic signed [PRICE_W-1:0] random_price();
    case ($urandom_range(0, 19))
      0:       return P_MAX;
      1:       return P_MIN;
      2:       return '0;
      3:       return '1;
      default: return $urandom();
    endcase
  endfunction

  // One price request; valid stays up across back-to-back requests
  task automatic send_update(input int sec, input logic signed [PRICE_W-1:0] price);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    security_index <= SEC_IDX_W'(sec);
    new_price      <= price;
    do @(posedge clk); while (!in_ready);
    requests_sent++;
  endtask

  // Hold the sender until every predicted total has come back
  task automatic wait_for_totals();
    in_valid <= 1'b0;
    do @(negedge clk); while (totals_outstanding != 0);
    @(posedge clk);
  endtask

  // Totals drained, then room for a ready step that gives no result
  task automatic settle();
    wait_for_totals();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register index equals the security number
  task automatic load_weights();
    for (int i = 0; i < 8; i++) begin
      cfg_write_en <= 1'b1;
      cfg_index    <= CFG_IDX_W'(i);
      cfg_data     <= weights[i];
      @(posedge clk);
    end
    cfg_write_en <= 1'b0;
  endtask

  initial begin
    logic signed [PRICE_W-1:0] repeat_price;
    int burst;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: extreme, unit and zero weights; securities 2 and 7 stay out
    weights    = '{W_MAX, W_MIN, '0, 24'sd1, -24'sd1, '0, W_ONE, '0};
    weights[5] = WEIGHT_W'($urandom()) | 24'sd1;
    load_weights();
    stall_pct = 20;

    // Before the set is complete nothing comes back
    send_update(0, P_MAX);
    send_update(1, P_MIN);
    send_update(2, random_price());
    send_update(3, '0);
    send_update(0, P_MIN);
    send_update(4, '1);
    send_update(5, random_price());
    send_update(6, 32'sh100);   // completes the set: rebuild, no result

    // Tracking: every request gives the new total
    repeat_price = random_price();
    send_update(7, P_MAX);      // zero weight, total unchanged
    send_update(0, P_MAX);
    send_update(1, P_MAX);
    send_update(3, P_MAX);
    send_update(4, P_MIN);
    send_update(5, repeat_price);
    send_update(5, repeat_price);
    send_update(6, P_MIN);
    send_update(2, '0);

    // New weights only act on later changes
    settle();
    weights[0] = -W_ONE;
    weights[2] = W_MAX;
    weights[7] = W_MIN;
    load_weights();
    send_update(2, P_MIN);
    send_update(0, '0);
    send_update(7, P_MIN);
    send_update(7, P_MAX);

    // Drive the total into the upper limit, then all the way down into the lower one.
    // Flipping the weight sign each phase lets full-range price swings keep adding.
    for (int flip = 0; flip < RISING_FLIPS + FALLING_FLIPS; flip++) begin
      bit rising;
      bit positive;
      bit up_price;
      rising   = flip < RISING_FLIPS;
      positive = (flip % 2) == 0;
      up_price = positive == rising;
      settle();
      for (int i = 0; i < 8; i++)
        weights[i] = positive ? W_MAX : W_MIN;
      load_weights();
      gap_pct   = phase_idle_pct();
      stall_pct = phase_idle_pct();
      for (int sec = 0; sec < 8; sec++)
        send_update(sec, up_price ? P_MAX - PRICE_W'($urandom_range(0, 255))
                                  : P_MIN + PRICE_W'($urandom_range(0, 255)));
    end

    // Random phases, some with fresh weights
    while (requests_sent < TOTAL_REQUESTS) begin
      if ($urandom_range(0, 1) == 0) begin
        settle();
        for (int i = 0; i < 8; i++)
          weights[i] = random_weight();
        load_weights();
      end
      gap_pct   = phase_idle_pct();
      stall_pct = phase_idle_pct();
      burst     = $urandom_range(8, 40);
      repeat (burst) begin
        send_update($urandom_range(0, 7), random_price());
        if ($urandom_range(0, 29) == 0)
          wait_for_totals();
      end
    end

    wait_for_totals();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && totals_outstanding == 0)
      $display("PASS weighted_portfolio_price_tracker_unit");
    else
      $display("FAIL weighted_portfolio_price_tracker_unit");
    $finish;
  end

endmodule

// ----- weighted_portfolio_price_tracker_unit.f -----
design/wppt_pkg.sv
design/weighted_portfolio_price_tracker_unit.sv
tb/portfolio_total_checker.sv
tb/weighted_portfolio_price_tracker_unit_tb.sv
